// ----- rtl/fir_filter_circular_fract_core_macros.svh -----
// Assertion macros for the FIR core.
`ifndef FIR_FILTER_CIRCULAR_FRACT_CORE_MACROS_SVH
`define FIR_FILTER_CIRCULAR_FRACT_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define FIRC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("firc assertion failed");

// next-cycle implication, clocked on clk, off during rst
`define FIRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("firc assertion failed");

`endif

// ----- rtl/firc_pkg.sv -----
`timescale 1ns / 1ps

package firc_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TAP_W       = 7;
  localparam int KIND_W      = 2;
  localparam int COEFF_IDX_W = 6;
  localparam int CFG_IDX_W   = 1;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COEFF  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 1'b1;

  localparam logic [TAP_W-1:0]           TAP_COUNT_RST   = 7'd64;
  localparam logic signed [SAMPLE_W-1:0] OUTPUT_GAIN_RST = 16'sd9830;

  typedef logic [KIND_W-1:0]           kind_t;
  typedef logic signed [SAMPLE_W-1:0]  q15_t;
  typedef logic [COEFF_IDX_W-1:0]      coeff_idx_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic [SAMPLE_W-1:0]         cfg_data_t;
  typedef logic [TAP_W-1:0]            tap_count_t;

  typedef struct packed {
    logic clip;
    q15_t val;
  } sat_t;

  typedef struct packed {
    logic store;
    logic coef_wr;
    logic clear;
    logic issue;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic busy;
    logic out_free;
  } stat_t;

  function automatic sat_t sat17(input logic signed [SAMPLE_W:0] v);
    sat_t r;
    if (v > 17'sd32767) begin
      r.clip = 1'b1;
      r.val  = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r.clip = 1'b1;
      r.val  = 16'sh8000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/firc_if.sv -----
`timescale 1ns / 1ps

interface firc_in_if;
  import firc_pkg::*;
  logic       valid;
  logic       ready;
  kind_t      kind;
  q15_t       sample;
  coeff_idx_t coeff_index;
  q15_t       coeff_value;
  modport source (output valid, kind, sample, coeff_index, coeff_value, input ready);
  modport sink (input valid, kind, sample, coeff_index, coeff_value, output ready);
endinterface

interface firc_out_if;
  import firc_pkg::*;
  logic valid;
  logic ready;
  q15_t filtered_sample;
  logic clipped;
  modport source (output valid, filtered_sample, clipped, input ready);
  modport sink (input valid, filtered_sample, clipped, output ready);
endinterface

// ----- rtl/firc_ctrl.sv -----
`timescale 1ns / 1ps

module firc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  firc_pkg::kind_t kind,
  output logic            item_ready,
  input  firc_pkg::stat_t stat,
  output firc_pkg::cmd_t  cmd
);
  import firc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    item_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          unique case (kind)
            KIND_SAMPLE: begin
              cmd.store  = 1'b1;
              state_next = ST_RUN;
            end
            KIND_COEFF: cmd.coef_wr = 1'b1;
            KIND_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.busy && stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

// ----- rtl/firc_dp.sv -----
`timescale 1ns / 1ps

module firc_dp #(
  parameter int MAX_TAP_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  firc_pkg::cmd_t       cmd,
  output firc_pkg::stat_t      stat,
  input  logic                 cfg_write,
  input  firc_pkg::cfg_idx_t   cfg_index,
  input  firc_pkg::cfg_data_t  cfg_data,
  input  firc_pkg::q15_t       sample,
  input  firc_pkg::coeff_idx_t coeff_index,
  input  firc_pkg::q15_t       coeff_value,
  firc_out_if.source           result
);
  import firc_pkg::*;

  localparam int AW = $clog2(MAX_TAP_COUNT);
  localparam int CW = $clog2(MAX_TAP_COUNT + 1);
  localparam int TW = (CW > TAP_W) ? CW : TAP_W;
  localparam int IW = (CW > COEFF_IDX_W) ? CW : COEFF_IDX_W;

  tap_count_t tap_count;
  q15_t       output_gain;

  q15_t hist_mem [MAX_TAP_COUNT];
  q15_t coef_mem [MAX_TAP_COUNT];
  logic [MAX_TAP_COUNT-1:0] hist_vld;
  logic [MAX_TAP_COUNT-1:0] coef_vld;

  logic [AW-1:0] write_position;
  logic [AW-1:0] rd_k;
  logic [AW-1:0] rd_m;

  logic [TW-1:0] tc_ext;
  logic [CW-1:0] eff_n;
  logic [AW-1:0] pos_now;
  logic [AW-1:0] pos_next;
  logic [AW-1:0] k_next;
  logic [IW-1:0] idx_ext;
  logic          idx_ok;

  logic s1_v, s2_v, s3_v;
  q15_t rd_c, rd_h;
  logic rd_cv, rd_hv;
  q15_t c_eff, h_eff;
  logic signed [2*SAMPLE_W-1:0] p1;
  logic signed [2*SAMPLE_W-1:0] p2;
  logic clip3;
  sat_t t1, t2, acc_sat;
  q15_t t1_val;
  q15_t acc;
  logic clip_acc;
  logic signed [SAMPLE_W:0] sum;

  logic out_valid;
  q15_t out_sample;
  logic out_clip;

  always_comb begin
    tc_ext = TW'(tap_count);
    if (tc_ext == '0) eff_n = CW'(1);
    else if (tc_ext > TW'(MAX_TAP_COUNT)) eff_n = CW'(MAX_TAP_COUNT);
    else eff_n = tc_ext[CW-1:0];
    pos_now  = (CW'(write_position) >= eff_n) ? '0 : write_position;
    pos_next = ((CW'(pos_now) + CW'(1)) >= eff_n) ? '0 : pos_now + AW'(1);
    k_next   = ((CW'(rd_k) + CW'(1)) >= eff_n) ? '0 : rd_k + AW'(1);
    idx_ext  = IW'(coeff_index);
    idx_ok   = idx_ext < IW'(MAX_TAP_COUNT);
  end

  assign stat.last     = (CW'(rd_m) == eff_n - CW'(1));
  assign stat.busy     = s1_v | s2_v | s3_v;
  assign stat.out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count   <= TAP_COUNT_RST;
      output_gain <= OUTPUT_GAIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TAP_COUNT:   tap_count <= cfg_data[TAP_W-1:0];
        REG_OUTPUT_GAIN: output_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample and coefficient stores, registered read
  always_ff @(posedge clk) begin
    if (cmd.store) hist_mem[pos_now] <= sample;
    if (cmd.coef_wr && idx_ok) coef_mem[idx_ext[AW-1:0]] <= coeff_value;
    rd_h <= hist_mem[rd_k];
    rd_c <= coef_mem[rd_m];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      hist_vld       <= '0;
      coef_vld       <= '0;
      write_position <= '0;
    end else begin
      if (cmd.store) begin
        hist_vld[pos_now] <= 1'b1;
        write_position    <= pos_next;
      end
      if (cmd.coef_wr && idx_ok) coef_vld[idx_ext[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rd_k <= pos_next;
      rd_m <= '0;
    end else if (cmd.issue) begin
      rd_k <= k_next;
      rd_m <= rd_m + AW'(1);
    end
    rd_hv <= hist_vld[rd_k];
    rd_cv <= coef_vld[rd_m];
  end

  always_comb begin
    c_eff   = rd_cv ? rd_c : '0;
    h_eff   = rd_hv ? rd_h : '0;
    t1      = sat17(p1[2*SAMPLE_W-1:SAMPLE_W-1]);
    t1_val  = t1.val;
    t2      = sat17(p2[2*SAMPLE_W-1:SAMPLE_W-1]);
    sum     = (SAMPLE_W+1)'(acc) + (SAMPLE_W+1)'(t2.val);
    acc_sat = sat17(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    p1    <= c_eff * h_eff;
    p2    <= t1_val * output_gain;
    clip3 <= t1.clip;
    if (cmd.store) begin
      acc      <= '0;
      clip_acc <= 1'b0;
    end else if (s3_v) begin
      acc      <= acc_sat.val;
      clip_acc <= clip_acc | clip3 | t2.clip | acc_sat.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load) out_valid <= 1'b1;
    else if (result.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_sample <= acc;
      out_clip   <= clip_acc;
    end
  end

  assign result.valid           = out_valid;
  assign result.filtered_sample = out_sample;
  assign result.clipped         = out_clip;

endmodule

// ----- rtl/fir_filter_circular_fract_core.sv -----
`timescale 1ns / 1ps
// Port       Role    Moves
// item       sink    kind, sample, coeff_index, coeff_value
// result     source  filtered_sample, clipped (one per sample item)
// cfg_*      write   tap_count (index 0), output_gain (index 1)
//
// A sample item loads its result once its walk of the n taps in use has drained the
// pipe, and the next item can transfer in the cycle after the load; one shared
// multiplier pair walks the taps one per cycle through a four-stage pipe.
// Coefficient, clear and unused items are taken without starting a walk.
// Synchronous reset empties history and coefficients at once through valid bits.
// A waiting result holds in the output register while the next item is taken;
// a walk that ends while it still waits holds until it transfers.

`include "fir_filter_circular_fract_core_macros.svh"

module fir_filter_circular_fract_core #(
  parameter int MAX_TAP_COUNT = 64
) (
  input  logic                clk,
  input  logic                rst,
  firc_in_if.sink             item,
  firc_out_if.source          result,
  input  logic                cfg_write,
  input  firc_pkg::cfg_idx_t  cfg_index,
  input  firc_pkg::cfg_data_t cfg_data
);
  import firc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  firc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .kind       (item.kind),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  firc_dp #(
    .MAX_TAP_COUNT (MAX_TAP_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (item.sample),
    .coeff_index (item.coeff_index),
    .coeff_value (item.coeff_value),
    .result      (result)
  );

  `FIRC_ASSERT_IMP(a_accept_pipe_empty, item.valid && item.ready, !stat.busy)
  `FIRC_ASSERT_IMP(a_load_slot_free, cmd.load, stat.out_free && !stat.busy)
  `FIRC_ASSERT_NEXT(a_store_starts_walk, cmd.store, cmd.issue && !item.ready)

endmodule
